// ===== rtl/core/gpsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gpsb_pkg
// Shared types and constants for the glyph pixel shade blender.
// ----------------------------------------------------------------------------
package gpsb_pkg;

   typedef enum logic [3:0] {
      FN_PLAIN       = 4'd0,
      FN_DARK        = 4'd1,
      FN_DARK_ADJ    = 4'd2,
      FN_RECOLOR     = 4'd3,
      FN_SOLID       = 4'd4,
      FN_GLOW        = 4'd5,
      FN_BRIGHT_GLOW = 4'd6,
      FN_UNGLOW      = 4'd7,
      FN_GLOW_LIM    = 4'd8,
      FN_UNGLOW_LIM  = 4'd9,
      FN_UNGLOW_SIDE = 4'd10,
      FN_PAL_WRITE   = 4'd11
   } func_type;

   // what the back stage does with the prepared step
   typedef enum logic [1:0] {
      OP_DIRECT,
      OP_ADD,
      OP_SUB,
      OP_BRIGHT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       go;
      logic [7:0] step;
      logic [7:0] direct;
      logic [7:0] dest;
   } shade_stage_type;

   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

   localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

   localparam logic [4:0] SHADE_MAX = 5'd31;

endpackage

// ===== rtl/core/gpsb_palette.sv =====
// ----------------------------------------------------------------------------
// gpsb_palette
// Shade palette memory with per-entry valid bits; unwritten entries read as
// their own index. Read data is registered.
// ----------------------------------------------------------------------------
module gpsb_palette #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int IDX_W = $clog2(PALETTE_ENTRIES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0]                 palette_mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [PALETTE_ENTRIES-1:0] valid_in;
   logic [7:0]                 mem_q_ff;
   logic                       vld_q_ff;
   logic [IDX_W-1:0]           idx_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= palette_mem_ff[rd_addr];
         vld_q_ff <= valid_ff[rd_addr];
         idx_q_ff <= rd_addr;
      end
   end

   // identity value for an entry never written
   assign rd_data = vld_q_ff ? mem_q_ff : 8'(idx_q_ff);

`ifndef NO_ASSERTIONS
   a_wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("palette entry not marked valid after write");
`endif

endmodule

// ===== rtl/core/gpsb_front.sv =====
// ----------------------------------------------------------------------------
// gpsb_front
// Input stage registers, clipping tests and shade step preparation.
// ----------------------------------------------------------------------------
module gpsb_front
   import gpsb_pkg::*;
(
   input  logic                   clock,
   input  logic                   load_in,
   input  logic                   load_mid,
   input  logic [3:0]             func,
   input  logic [7:0]             glyph_pixel,
   input  logic [7:0]             dest_pixel,
   input  logic signed [12:0]     pos_x,
   input  logic signed [12:0]     pos_y,
   input  logic signed [7:0]      amount,
   input  logic [7:0]             tint,
   input  logic [11:0]            right_limit,
   input  logic signed [12:0]     top_limit,
   input  logic [7:0]             pal_data,
   input  logic [11:0]            screen_width,
   input  logic [11:0]            screen_height,
   output shade_stage_type        mid
);

   func_type           func_ff;
   logic [7:0]         glyph_ff;
   logic [7:0]         dest_ff;
   logic signed [12:0] x_ff;
   logic signed [12:0] y_ff;
   logic signed [7:0]  amt_ff;
   logic [7:0]         tint_ff;
   logic [11:0]        rlim_ff;
   logic signed [12:0] tlim_ff;
   shade_stage_type    mid_ff;
   shade_stage_type    mid_in;

   logic signed [12:0] w_s;
   logic signed [12:0] h_s;
   logic signed [12:0] rl_s;
   logic signed [13:0] x_w;
   logic signed [13:0] wm1;
   logic signed [13:0] rl_w;
   logic signed [13:0] lim;
   logic               y_in_full;
   logic               in_full;
   logic               in_strict;
   logic               ok_glow_lim;
   logic               ok_unglow_lim;
   logic               ok_unglow_side;
   logic [4:0]         pshade;
   logic [4:0]         gshade;
   logic [6:0]         dark_k;
   logic [4:0]         dadj;
   logic signed [8:0]  glow_sum;
   logic signed [8:0]  glim_sum;
   logic [7:0]         bright_b;
   logic [7:0]         rc_b;
   logic [4:0]         rc_shade;
   logic               amt_pos;

   always_ff @(posedge clock) begin
      if (load_in) begin
         func_ff  <= func_type'(func);
         glyph_ff <= glyph_pixel;
         dest_ff  <= dest_pixel;
         x_ff     <= pos_x;
         y_ff     <= pos_y;
         amt_ff   <= amount;
         tint_ff  <= tint;
         rlim_ff  <= right_limit;
         tlim_ff  <= top_limit;
      end
   end

   always_comb begin
      w_s  = $signed({1'b0, screen_width});
      h_s  = $signed({1'b0, screen_height});
      rl_s = $signed({1'b0, rlim_ff});
      x_w  = {x_ff[12], x_ff};
      wm1  = $signed({2'b00, screen_width}) - 14'sd1;
      rl_w = $signed({2'b00, rlim_ff});
      lim  = (rl_w < wm1) ? rl_w : wm1;

      y_in_full      = !y_ff[12] && (y_ff < h_s);
      in_full        = !x_ff[12] && (x_ff < w_s) && y_in_full;
      in_strict      = (x_ff > 13'sd0) && (x_ff < w_s) && (y_ff > 13'sd0) && (y_ff < h_s);
      ok_glow_lim    = !x_ff[12] && (x_w < lim) && y_in_full;
      ok_unglow_lim  = !x_ff[12] && (x_ff < rl_s) && y_in_full;
      ok_unglow_side = (x_ff > 13'sd0) && (x_ff < w_s) && (y_ff > tlim_ff) && (y_ff < h_s);

      pshade = pal_data[4:0];
      gshade = glyph_ff[4:0];
      amt_pos = !amt_ff[7] && (amt_ff != 8'sd0);

      // negative darkness counts as none
      dark_k = amt_ff[7] ? 7'd0 : amt_ff[6:0];
      dadj   = ({2'b00, pshade} > dark_k) ? (pshade - dark_k[4:0]) : 5'd0;

      glow_sum = $signed({4'b0000, pshade}) + {amt_ff[7], amt_ff};
      glim_sum = $signed({4'b0000, gshade}) + {amt_ff[7], amt_ff};
      bright_b = dest_ff + {3'b000, gshade} + amt_ff;

      // recolor leaves the shade saturated if it left the glyph's group
      rc_b = glyph_ff + amt_ff;
      if (rc_b[7:5] != glyph_ff[7:5]) begin
         rc_shade = amt_pos ? SHADE_MAX : 5'd0;
      end else begin
         rc_shade = rc_b[4:0];
      end
   end

   always_comb begin
      mid_in.op     = OP_DIRECT;
      mid_in.go     = 1'b0;
      mid_in.step   = {3'b000, pshade};
      mid_in.direct = pal_data;
      mid_in.dest   = dest_ff;
      case (func_ff)
         FN_PLAIN: begin
            mid_in.go = in_full;
         end
         FN_DARK: begin
            mid_in.op = OP_SUB;
            mid_in.go = in_strict && (pshade != 5'd0);
         end
         FN_DARK_ADJ: begin
            mid_in.op   = OP_SUB;
            mid_in.go   = in_strict && (dadj != 5'd0);
            mid_in.step = {3'b000, dadj};
         end
         FN_RECOLOR: begin
            mid_in.go     = in_full;
            mid_in.direct = {tint_ff[2:0], rc_shade};
         end
         FN_SOLID: begin
            mid_in.go     = in_full;
            mid_in.direct = tint_ff;
         end
         FN_GLOW: begin
            mid_in.op   = OP_ADD;
            mid_in.go   = in_strict && (glow_sum > 9'sd0);
            mid_in.step = glow_sum[7:0];
         end
         FN_BRIGHT_GLOW: begin
            mid_in.op     = OP_BRIGHT;
            mid_in.go     = in_strict && (glim_sum > 9'sd0);
            mid_in.direct = bright_b;
         end
         FN_UNGLOW: begin
            mid_in.op = OP_SUB;
            mid_in.go = in_full && (pshade != 5'd0);
         end
         FN_GLOW_LIM: begin
            mid_in.op   = OP_ADD;
            mid_in.go   = ok_glow_lim && (glim_sum > 9'sd0);
            mid_in.step = glim_sum[7:0];
         end
         FN_UNGLOW_LIM: begin
            mid_in.op = OP_SUB;
            mid_in.go = ok_unglow_lim && (pshade != 5'd0);
         end
         FN_UNGLOW_SIDE: begin
            mid_in.op = OP_SUB;
            mid_in.go = ok_unglow_side && (pshade != 5'd0);
         end
         default: begin
            mid_in.go = 1'b0;
         end
      endcase
      // transparent glyph never draws
      if (glyph_ff == 8'd0) begin
         mid_in.go = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_mid) begin
         mid_ff <= mid_in;
      end
   end

   assign mid = mid_ff;

endmodule

// ===== rtl/core/gpsb_back.sv =====
// ----------------------------------------------------------------------------
// gpsb_back
// Saturating shade arithmetic, result select and output register.
// ----------------------------------------------------------------------------
module gpsb_back
   import gpsb_pkg::*;
(
   input  logic            clock,
   input  logic            load_out,
   input  shade_stage_type mid,
   output logic [7:0]      new_pixel,
   output logic            write_enable
);

   logic [7:0] pixel_ff;
   logic [7:0] pixel_in;
   logic       we_ff;
   logic       we_in;
   logic [4:0] ds;
   logic [2:0] grp;
   logic [8:0] add_sum;
   logic [4:0] sub_v;
   logic [4:0] add_v;

   always_comb begin
      ds      = mid.dest[4:0];
      grp     = mid.dest[7:5];
      add_sum = {4'b0000, ds} + {1'b0, mid.step};
      add_v   = (add_sum > {4'b0000, SHADE_MAX}) ? SHADE_MAX : add_sum[4:0];
      sub_v   = (ds > mid.step[4:0]) ? (ds - mid.step[4:0]) : 5'd0;

      pixel_in = mid.direct;
      we_in    = mid.go;
      case (mid.op)
         OP_DIRECT: begin
            pixel_in = mid.direct;
         end
         OP_ADD: begin
            pixel_in = {grp, add_v};
         end
         OP_SUB: begin
            pixel_in = {grp, sub_v};
         end
         OP_BRIGHT: begin
            if (mid.direct[7:5] != grp) begin
               pixel_in = {grp, SHADE_MAX};
            end else if (mid.direct > mid.dest) begin
               pixel_in = mid.direct;
            end else begin
               we_in = 1'b0;
            end
         end
         default: begin
            we_in = 1'b0;
         end
      endcase
      if (!we_in) begin
         pixel_in = mid.dest;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         pixel_ff <= pixel_in;
         we_ff    <= we_in;
      end
   end

   assign new_pixel    = pixel_ff;
   assign write_enable = we_ff;

endmodule

// ===== rtl/core/glyph_pixel_shade_blender_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_shade_blender_unit
// Per-pixel blender for palette-indexed text: clipping, shade darken/glow
// modes with saturation, recolor, solid fill and shade palette writes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  func, pixels, position, amounts
//  rsp       out        rsp_valid / rsp_stall  new_pixel, write_enable
//  csr       in/out     apb psel/penable       screen_width, screen_height
//
//  one item per clock while rsp_stall does not hold the pipeline; an item passes
//  the input/palette read stage, the step stage and the output register in turn
//  and shows on rsp_valid once it is in the output register
//  reset clears pipeline valids and palette valid bits and loads the size
//  registers with 640 x 480; an unwritten palette entry reads as its own index
//  rsp_stall holds each occupied stage with no free stage ahead; req_stall rises
//  only when all three stages are full and the output is stalled
// ----------------------------------------------------------------------------
module glyph_pixel_shade_blender_unit
   import gpsb_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_func,
   input  logic [7:0]         req_glyph_pixel,
   input  logic [7:0]         req_dest_pixel,
   input  logic signed [12:0] req_pos_x,
   input  logic signed [12:0] req_pos_y,
   input  logic signed [7:0]  req_amount,
   input  logic [7:0]         req_tint,
   input  logic [11:0]        req_right_limit,
   input  logic signed [12:0] req_top_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_new_pixel,
   output logic               rsp_write_enable,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic            v1_ff;
   logic            v2_ff;
   logic            v3_ff;
   logic            en1;
   logic            en2;
   logic            en3;
   logic            accept;
   logic            pal_wr;
   logic [11:0]     width_ff;
   logic [11:0]     height_ff;
   logic            csr_wr;
   logic [7:0]      pal_data;
   shade_stage_type mid;

   // a stage loads when it is empty or its content moves on
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign pal_wr    = accept && (func_type'(req_func) == FN_PAL_WRITE);
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr)
            REG_SCREEN_WIDTH:  width_ff  <= csr_pwdata[11:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         REG_SCREEN_WIDTH:  csr_prdata = {20'd0, width_ff};
         REG_SCREEN_HEIGHT: csr_prdata = {20'd0, height_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   gpsb_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .IDX_W           (IDX_W)
   ) u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pal_wr),
      .wr_addr (req_glyph_pixel[IDX_W-1:0]),
      .wr_data (req_dest_pixel),
      .rd_en   (en1),
      .rd_addr (req_glyph_pixel[IDX_W-1:0]),
      .rd_data (pal_data)
   );

   gpsb_front u_front (
      .clock         (clock),
      .load_in       (en1),
      .load_mid      (en2),
      .func          (req_func),
      .glyph_pixel   (req_glyph_pixel),
      .dest_pixel    (req_dest_pixel),
      .pos_x         (req_pos_x),
      .pos_y         (req_pos_y),
      .amount        (req_amount),
      .tint          (req_tint),
      .right_limit   (req_right_limit),
      .top_limit     (req_top_limit),
      .pal_data      (pal_data),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .mid           (mid)
   );

   gpsb_back u_back (
      .clock        (clock),
      .load_out     (en3),
      .mid          (mid),
      .new_pixel    (rsp_new_pixel),
      .write_enable (rsp_write_enable)
   );

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled with a free pipeline stage");

   a_mid_kept: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff && rsp_stall) |=> v2_ff)
      else $error("middle stage item lost under output stall");
`endif

endmodule

// ===== bench/glyph_pixel_shade_blender_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_pixel_shade_blender_unit_test
// Self-checking bench for the glyph pixel shade blender. A scoreboard keeps
// its own palette and frame size, predicts each pixel result as items are
// accepted and compares the returned pixels in order. Stimulus is a short
// directed list and then random pixels under several frame sizes, with
// random idling on both channels, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
package gpsb_bench_pkg;
   import gpsb_pkg::*;

   // selector codes the block has no mode for
   localparam logic [3:0] FN_UNUSED_LO = 4'd12;
   localparam logic [3:0] FN_UNUSED_HI = 4'd15;

   typedef struct {
      logic [3:0]         func;
      logic [7:0]         glyph;
      logic [7:0]         dest;
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic signed [7:0]  amount;
      logic [7:0]         tint;
      logic [11:0]        right_limit;
      logic signed [12:0] top_limit;
   } pixel_req_type;

   typedef struct {
      logic [7:0] new_pixel;
      logic       write_enable;
   } pixel_rsp_type;

   class shade_blend_board;
      logic [7:0]    palette [256];
      logic [11:0]   width;
      logic [11:0]   height;
      pixel_rsp_type pending_q [$];
      int            n_items;
      int            n_checked;
      int            n_errors;
      int            n_pal_writes;
      int            n_writes;

      function new();
         foreach (palette[i]) palette[i] = 8'(i);
         width  = SCREEN_WIDTH_RESET;
         height = SCREEN_HEIGHT_RESET;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void note_error(string msg);
         n_errors++;
         if (n_errors <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function pixel_rsp_type predict_pixel(pixel_req_type r);
         pixel_rsp_type res;
         int x, y, amt, rlim, tlim, w, h, ds, gs, ps, s, v, lim, b;
         bit in_full, in_strict, ok;
         logic [7:0] np;
         bit we;
         x    = int'(r.pos_x);
         y    = int'(r.pos_y);
         amt  = int'(r.amount);
         rlim = int'(r.right_limit);
         tlim = int'(r.top_limit);
         w    = int'(width);
         h    = int'(height);
         ds   = int'(r.dest[4:0]);
         gs   = int'(r.glyph[4:0]);
         ps   = int'(palette[r.glyph][4:0]);
         in_full   = x >= 0 && x < w && y >= 0 && y < h;
         in_strict = x > 0 && x < w && y > 0 && y < h;
         np = r.dest;
         we = 1'b0;
         if (r.func == FN_PAL_WRITE) begin
            palette[r.glyph] = r.dest;
            n_pal_writes++;
         end else if (r.func <= FN_UNGLOW_SIDE && r.glyph != 8'd0) begin
            case (r.func)
               FN_PLAIN: begin
                  if (in_full) begin
                     np = palette[r.glyph];
                     we = 1'b1;
                  end
               end
               FN_SOLID: begin
                  if (in_full) begin
                     np = r.tint;
                     we = 1'b1;
                  end
               end
               FN_DARK, FN_DARK_ADJ: begin
                  if (in_strict) begin
                     s = ps;
                     // negative darkness counts as none
                     if (r.func == FN_DARK_ADJ) begin
                        s = s - ((amt < 0) ? 0 : amt);
                        if (s < 0) s = 0;
                     end
                     if (s > 0) begin
                        v = ds - s;
                        if (v < 0) v = 0;
                        np = {r.dest[7:5], v[4:0]};
                        we = 1'b1;
                     end
                  end
               end
               FN_RECOLOR: begin
                  if (in_full) begin
                     b = (int'(r.glyph) + amt) & 255;
                     // leaving the colour group pins the shade
                     if (b[7:5] != r.glyph[7:5]) b = (amt > 0) ? int'(SHADE_MAX) : 0;
                     np = {r.tint[2:0], b[4:0]};
                     we = 1'b1;
                  end
               end
               FN_GLOW, FN_GLOW_LIM: begin
                  lim = (rlim < w - 1) ? rlim : w - 1;
                  if (r.func == FN_GLOW) begin
                     ok = in_strict;
                     s  = ps + amt;
                  end else begin
                     ok = x >= 0 && x < lim && y >= 0 && y < h;
                     s  = gs + amt;
                  end
                  if (ok && s > 0) begin
                     v = ds + s;
                     if (v > int'(SHADE_MAX)) v = int'(SHADE_MAX);
                     np = {r.dest[7:5], v[4:0]};
                     we = 1'b1;
                  end
               end
               FN_BRIGHT_GLOW: begin
                  if (in_strict && gs + amt > 0) begin
                     b = (int'(r.dest) + gs + amt) & 255;
                     if (b[7:5] != r.dest[7:5]) begin
                        np = {r.dest[7:5], SHADE_MAX};
                        we = 1'b1;
                     end else if (b > int'(r.dest)) begin
                        np = b[7:0];
                        we = 1'b1;
                     end
                  end
               end
               FN_UNGLOW, FN_UNGLOW_LIM, FN_UNGLOW_SIDE: begin
                  if (r.func == FN_UNGLOW) ok = in_full;
                  else if (r.func == FN_UNGLOW_LIM)
                     ok = x >= 0 && x < rlim && y >= 0 && y < h;
                  else ok = x > 0 && x < w && y > tlim && y < h;
                  if (ok && ps > 0) begin
                     v = ds - ps;
                     if (v < 0) v = 0;
                     np = {r.dest[7:5], v[4:0]};
                     we = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         res.new_pixel    = np;
         res.write_enable = we;
         return res;
      endfunction

      function void note_pixel(pixel_req_type r);
         pixel_rsp_type res;
         res = predict_pixel(r);
         pending_q.push_back(res);
         n_items++;
         if (res.write_enable) n_writes++;
      endfunction

      function void check_pixel(logic [7:0] np, logic we);
         pixel_rsp_type want;
         if (pending_q.size() == 0) begin
            note_error($sformatf("result with none pending: new_pixel %02h write_enable %0b",
                                 np, we));
            return;
         end
         want = pending_q.pop_front();
         n_checked++;
         if (np !== want.new_pixel)
            note_error($sformatf("result %0d new_pixel expected %02h got %02h",
                                 n_checked, want.new_pixel, np));
         if (we !== want.write_enable)
            note_error($sformatf("result %0d write_enable expected %0b got %0b",
                                 n_checked, want.write_enable, we));
      endfunction
   endclass

endpackage

module glyph_pixel_shade_blender_unit_test;
   import gpsb_pkg::*;
   import gpsb_bench_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_CYCLES    = 150;
   localparam int ITEMS_PER_SIZE = 250;
   localparam int N_SIZES        = 6;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [3:0]         req_func         = FN_PLAIN;
   logic [7:0]         req_glyph_pixel  = 8'd0;
   logic [7:0]         req_dest_pixel   = 8'd0;
   logic signed [12:0] req_pos_x        = 13'sd0;
   logic signed [12:0] req_pos_y        = 13'sd0;
   logic signed [7:0]  req_amount       = 8'sd0;
   logic [7:0]         req_tint         = 8'd0;
   logic [11:0]        req_right_limit  = 12'd0;
   logic signed [12:0] req_top_limit    = 13'sd0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [7:0]         rsp_new_pixel;
   logic               rsp_write_enable;
   logic               csr_psel         = 1'b0;
   logic               csr_penable      = 1'b0;
   logic               csr_pwrite       = 1'b0;
   logic [2:0]         csr_paddr        = REG_SCREEN_WIDTH;
   logic [31:0]        csr_pwdata       = 32'd0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   shade_blend_board board = new();

   int send_idle_pct = 14;
   int recv_idle_pct = 55;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int n_sizes_run   = 1;

   glyph_pixel_shade_blender_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_glyph_pixel  (req_glyph_pixel),
      .req_dest_pixel   (req_dest_pixel),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_amount       (req_amount),
      .req_tint         (req_tint),
      .req_right_limit  (req_right_limit),
      .req_top_limit    (req_top_limit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_pixel    (rsp_new_pixel),
      .rsp_write_enable (rsp_write_enable),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, board.pending());
      $display("Test completed with failures");
      $finish;
   end

   // result side: sample the handshake as it stood at the edge, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_pixel(rsp_new_pixel, rsp_write_enable);
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic pixel_req_type make_req(logic [3:0] f, int g, int d, int x, int y,
                                             int amt, int tint, int rlim, int tlim);
      pixel_req_type r;
      r.func        = f;
      r.glyph       = 8'(g);
      r.dest        = 8'(d);
      r.pos_x       = 13'(x);
      r.pos_y       = 13'(y);
      r.amount      = 8'(amt);
      r.tint        = 8'(tint);
      r.right_limit = 12'(rlim);
      r.top_limit   = 13'(tlim);
      return r;
   endfunction

   // mostly across the frame and one past it, often near its edges, now and then anywhere
   function automatic int pick_coord(int n);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return int'($urandom_range(0, n + 1)) - 1;
      if (sel < 85) return n + int'($urandom_range(0, 3)) - 2 - ((sel < 72) ? n : 0);
      return int'($urandom_range(0, 8191)) - 4096;
   endfunction

   function automatic pixel_req_type random_req();
      pixel_req_type r;
      int sel, x, y;
      sel = $urandom_range(0, 99);
      if (sel < 4) r.func = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      else if (sel < 12) r.func = FN_PAL_WRITE;
      else r.func = 4'($urandom_range(FN_PLAIN, FN_UNGLOW_SIDE));
      r.glyph  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      r.dest   = 8'($urandom);
      r.amount = 8'($urandom);
      r.tint   = 8'($urandom);
      x = pick_coord(int'(board.width));
      y = pick_coord(int'(board.height));
      r.pos_x = 13'(x);
      r.pos_y = 13'(y);
      case ($urandom_range(0, 2))
         0:       r.right_limit = 12'($urandom);
         1:       r.right_limit = 12'(x + int'($urandom_range(0, 2)) - 1);
         default: r.right_limit = 12'(int'(board.width) + int'($urandom_range(0, 2)) - 2);
      endcase
      if ($urandom_range(0, 1) == 0) r.top_limit = 13'($urandom);
      else r.top_limit = 13'(y - int'($urandom_range(0, 2)));
      return r;
   endfunction

   task automatic drive_req(pixel_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= r.func;
      req_glyph_pixel <= r.glyph;
      req_dest_pixel  <= r.dest;
      req_pos_x       <= r.pos_x;
      req_pos_y       <= r.pos_y;
      req_amount      <= r.amount;
      req_tint        <= r.tint;
      req_right_limit <= r.right_limit;
      req_top_limit   <= r.top_limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [11:0] value);
      logic [31:0] data;
      data       = $urandom;
      data[11:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_frame(logic [11:0] w, logic [11:0] h);
      write_csr(REG_SCREEN_WIDTH, w);
      board.width = w;
      write_csr(REG_SCREEN_HEIGHT, h);
      board.height = h;
      n_sizes_run++;
   endtask

   initial begin
      logic [11:0] size_w [N_SIZES];
      logic [11:0] size_h [N_SIZES];
      int i, k;
      size_w = '{12'd4095, 12'd1, 12'd37, 12'd4095, 12'd1, 12'd200};
      size_h = '{12'd4095, 12'd1, 12'd23, 12'd1, 12'd4095, 12'd100};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass on the reset frame size
      drive_req(make_req(FN_PAL_WRITE, 'h45, 'h03, 0, 0, 0, 0, 0, 0));
      drive_req(make_req(FN_PLAIN, 'h45, 'h00, 0, 0, 0, 0, 0, 0));
      drive_req(make_req(FN_PLAIN, 'h00, 'h77, 5, 5, 0, 0, 0, 0));
      drive_req(make_req(FN_DARK, 'h45, 'hFF, 1, 1, 0, 0, 0, 0));
      drive_req(make_req(FN_DARK, 'h45, 'hFF, 0, 1, 0, 0, 0, 0));
      drive_req(make_req(FN_DARK_ADJ, 'h45, 'hFF, 2, 2, -128, 0, 0, 0));
      drive_req(make_req(FN_DARK_ADJ, 'h45, 'hFF, 2, 2, 3, 0, 0, 0));
      drive_req(make_req(FN_RECOLOR, 'h1F, 'h00, 0, 0, 127, 'hFF, 0, 0));
      drive_req(make_req(FN_RECOLOR, 'h20, 'h00, 639, 479, -128, 'h02, 0, 0));
      drive_req(make_req(FN_SOLID, 'hFF, 'h00, 639, 479, 0, 'hAA, 0, 0));
      drive_req(make_req(FN_SOLID, 'hFF, 'h00, 640, 479, 0, 'hAA, 0, 0));
      drive_req(make_req(FN_SOLID, 'h01, 'h00, -4096, 4095, 0, 'h55, 4095, -4096));
      drive_req(make_req(FN_GLOW, 'h45, 'h10, 3, 3, -3, 0, 0, 0));
      drive_req(make_req(FN_GLOW, 'hFF, 'hFE, 3, 3, 127, 0, 0, 0));
      drive_req(make_req(FN_BRIGHT_GLOW, 'h01, 'h40, 4, 4, -1, 0, 0, 0));
      drive_req(make_req(FN_BRIGHT_GLOW, 'h1F, 'hFF, 4, 4, 127, 0, 0, 0));
      drive_req(make_req(FN_BRIGHT_GLOW, 'h05, 'h40, 4, 4, -4, 0, 0, 0));
      drive_req(make_req(FN_UNGLOW, 'h45, 'h62, 0, 0, 0, 0, 0, 0));
      drive_req(make_req(FN_GLOW_LIM, 'h10, 'h00, 638, 0, 0, 0, 4095, 0));
      drive_req(make_req(FN_GLOW_LIM, 'h10, 'h00, 639, 0, 0, 0, 4095, 0));
      drive_req(make_req(FN_UNGLOW_LIM, 'h1F, 'h9F, 4094, 10, 0, 0, 4095, 0));
      drive_req(make_req(FN_UNGLOW_SIDE, 'h1F, 'h3F, 1, 0, 0, 0, 0, -4096));
      drive_req(make_req(FN_UNGLOW_SIDE, 'h1F, 'h3F, 1, 0, 0, 0, 0, 4095));
      drive_req(make_req(FN_UNUSED_LO, 'hFF, 'h55, 1, 1, 0, 0, 0, 0));
      drive_req(make_req(FN_UNUSED_HI, 'hFF, 'hAA, 1, 1, 0, 0, 0, 0));

      for (k = 0; k < N_SIZES; k++) begin
         drain();
         set_frame(size_w[k], size_h[k]);
         // receiver stalls often first, then sender idles often, then neither idles
         if (k < 2) begin
            send_idle_pct = 14;
            recv_idle_pct = 55;
         end else if (k < 4) begin
            send_idle_pct = 55;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (i = 0; i < ITEMS_PER_SIZE; i++) begin
            if (k == 1 && i == 100) hold_requests++;
            if (k == 3 && i == 125) drain();
            drive_req(random_req());
         end
      end
      drain();
      repeat (10) @(posedge clock);

      $display("%0d pixel items over %0d frame sizes, %0d with a write, %0d palette writes",
               board.n_items, n_sizes_run, board.n_writes, board.n_pal_writes);
      $display("%0d results checked including an output hold-off and a drain pause",
               board.n_checked);
      if (board.n_errors == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", board.n_errors);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
